/* rtl/sensor_recovery_supervisor_top_assert.svh */
// Assertion macros for the sensor recovery supervisor checker.
// Self-contained; expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef SENSOR_RECOVERY_SUPERVISOR_TOP_ASSERT_SVH
`define SENSOR_RECOVERY_SUPERVISOR_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset
`define SRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies another in the same cycle
`define SRS_ASSERT_IMPL(label, pre, post, msg) \
    `SRS_ASSERT(label, (pre) |-> (post), msg)

// Check that a condition implies another in the next cycle
`define SRS_ASSERT_NEXT(label, pre, post, msg) \
    `SRS_ASSERT(label, (pre) |=> (post), msg)

`endif

/* rtl/srs_pkg.sv */
// Shared types, codes and helper functions of the sensor recovery supervisor.
// No dependencies; used by the top level and the checker.
package srs_pkg;

    // Width of the internal time base; time arithmetic wraps at this width
    localparam int TIME_BITS = 32;
    localparam int CMP_BITS  = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int CFG_INDEX_BITS = 3;

    typedef logic [TIME_BITS-1:0] time_t;

    // Event kinds
    typedef enum logic [1:0] {
        ACT_SERVICE = 2'd0,
        ACT_REPORT  = 2'd1,
        ACT_TAKE    = 2'd2,
        ACT_START   = 2'd3
    } action_t;

    // Driver condition codes (the spare code behaves as busy)
    localparam logic [1:0] COND_BUSY  = 2'd0;
    localparam logic [1:0] COND_READY = 2'd1;
    localparam logic [1:0] COND_ERROR = 2'd2;
    localparam logic [1:0] COND_SPARE = 2'd3;

    // Restart reason codes
    typedef enum logic [1:0] {
        REASON_NONE   = 2'd0,
        REASON_BUS    = 2'd1,
        REASON_ERRORS = 2'd2,
        REASON_STALE  = 2'd3
    } reason_t;

    // Mode codes as seen on the result item
    localparam logic [2:0] CODE_NOT_STARTED  = 3'd0;
    localparam logic [2:0] CODE_INITIALIZING = 3'd1;
    localparam logic [2:0] CODE_CONFIRMING   = 3'd2;
    localparam logic [2:0] CODE_ACTIVE       = 3'd3;
    localparam logic [2:0] CODE_RESTART_WAIT = 3'd4;
    localparam logic [2:0] CODE_OFFLINE_WAIT = 3'd5;
    localparam logic [2:0] CODE_BUS_WAIT     = 3'd6;
    localparam logic [2:0] CODE_ERROR        = 3'd7;

    // Supervisor state, one-hot
    typedef enum logic [7:0] {
        M_NOT_STARTED  = 8'b0000_0001,
        M_INITIALIZING = 8'b0000_0010,
        M_CONFIRMING   = 8'b0000_0100,
        M_ACTIVE       = 8'b0000_1000,
        M_RESTART_WAIT = 8'b0001_0000,
        M_OFFLINE_WAIT = 8'b0010_0000,
        M_BUS_WAIT     = 8'b0100_0000,
        M_ERROR        = 8'b1000_0000
    } mode_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RESTART_DELAY = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PROBE_PERIOD  = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STALE_RESTART = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DRIVER_STALE  = CFG_INDEX_BITS'(3);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_READ_ERR_LIM  = CFG_INDEX_BITS'(4);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CONFIRM_GOOD  = CFG_INDEX_BITS'(5);

    // Input item
    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now_ms;
        logic        bus_needs_recovery;
        logic        driver_start_ok;
        logic        bus_abort_error;
        logic [1:0]  driver_condition;
        logic [31:0] success_total;
        logic [31:0] failure_total;
        logic        sample_present;
        logic [31:0] sample_time_ms;
        logic        transfer_busy;
        logic        recovery_ok;
    } evt_t;

    // Result item
    typedef struct packed {
        logic [2:0]  mode;
        logic        online;
        logic        started;
        logic        recovery_pending;
        logic        request_taken;
        logic [1:0]  restart_reason;
        logic [31:0] restart_total;
        logic [7:0]  good_run;
        logic [7:0]  error_run;
        logic        driver_restart;
    } res_t;

    // True once at least dur ticks have passed since from, with wrap
    function automatic logic elapsed(time_t now, time_t from, logic [31:0] dur);
        time_t diff;
        diff = now - from;
        return CMP_BITS'(diff) >= CMP_BITS'(dur);
    endfunction

    // Saturating add of a wide increment onto an 8-bit count
    function automatic logic [7:0] sat_add8(logic [7:0] v, logic [31:0] inc);
        logic [31:0] room;
        room = 32'(8'hFF - v);
        if (inc >= room)
            return 8'hFF;
        return v + inc[7:0];
    endfunction

    // Map one-hot state to its result code
    function automatic logic [2:0] mode_code(mode_t m);
        logic [2:0] code;
        case (m)
            M_NOT_STARTED:  code = CODE_NOT_STARTED;
            M_INITIALIZING: code = CODE_INITIALIZING;
            M_CONFIRMING:   code = CODE_CONFIRMING;
            M_ACTIVE:       code = CODE_ACTIVE;
            M_RESTART_WAIT: code = CODE_RESTART_WAIT;
            M_OFFLINE_WAIT: code = CODE_OFFLINE_WAIT;
            M_BUS_WAIT:     code = CODE_BUS_WAIT;
            M_ERROR:        code = CODE_ERROR;
            default:        code = CODE_NOT_STARTED;
        endcase
        return code;
    endfunction

endpackage

/* rtl/sensor_recovery_supervisor_top.sv */
// Sensor recovery supervisor: event register, supervisor logic, result register.
// Depends on srs_pkg.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------
//  evt     | in        | evt_valid / evt_ready | evt_t, one event
//  res     | out       | res_valid / res_ready | res_t, one result per event
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each event is registered, evaluated from the event register and its result registered:
// the result is offered from the result register, one event per cycle sustained while res_ready is high.
// A result waiting on res_ready holds the event register, and evt_ready drops
// while that register holds an item that cannot fire, so at most two items are in flight.
// Reset clears the supervisor state and loads the default configuration.
// cfg_ready is always high; a write takes effect on the next event.
module sensor_recovery_supervisor_top
    import srs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      evt_valid,
    output logic                      evt_ready,
    input  evt_t                      evt,
    output logic                      res_valid,
    input  logic                      res_ready,
    output res_t                      res,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]               cfg_data
);

    // Configuration registers
    logic [31:0] restart_delay_reg;
    logic [31:0] probe_period_reg;
    logic [31:0] stale_restart_reg;
    logic [31:0] driver_stale_reg;
    logic [7:0]  read_err_lim_reg;
    logic [7:0]  confirm_good_reg;

    // Supervisor state
    mode_t       mode_reg,     mode_next;
    time_t       since_reg,    since_next;
    logic [31:0] sbase_reg,    sbase_next;
    logic [31:0] fbase_reg,    fbase_next;
    logic [7:0]  good_reg,     good_next;
    logic [7:0]  err_reg,      err_next;
    logic [31:0] restart_reg,  restart_next;
    reason_t     reason_reg,   reason_next;
    logic        pending_reg,  pending_next;
    logic        started_reg,  started_next;

    // Pipeline registers
    evt_t        evt_reg;
    logic        evt_valid_reg;
    res_t        res_reg,      res_next;
    logic        res_valid_reg;

    // Evaluation temporaries
    logic        fire;
    time_t       now_t;
    time_t       fresh_t;
    logic [31:0] wait_ms;
    logic [31:0] sdelta;
    logic [31:0] fdelta;
    logic [7:0]  good_v;
    logic [7:0]  err_v;
    logic        do_start;
    logic        bump;
    logic        taken;
    logic        drv;
    logic        cfg_bad;
    mode_t       start_mode;

    assign fire      = evt_valid_reg && (!res_valid_reg || res_ready);
    assign evt_ready = !evt_valid_reg || fire;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign now_t   = time_t'(evt_reg.now_ms);
    assign cfg_bad = (restart_delay_reg == '0) || (probe_period_reg == '0) ||
                     (stale_restart_reg == '0) || (driver_stale_reg == '0) ||
                     (read_err_lim_reg == '0) || (confirm_good_reg == '0) ||
                     (stale_restart_reg <= driver_stale_reg);

    // Evaluate one event against the current state
    always_comb
    begin
        mode_next    = mode_reg;
        since_next   = since_reg;
        sbase_next   = sbase_reg;
        fbase_next   = fbase_reg;
        good_next    = good_reg;
        err_next     = err_reg;
        restart_next = restart_reg;
        reason_next  = reason_reg;
        pending_next = pending_reg;
        started_next = started_reg;
        taken        = 1'b0;
        drv          = 1'b0;
        do_start     = 1'b0;
        bump         = 1'b0;
        wait_ms      = '0;
        fresh_t      = '0;
        sdelta       = evt_reg.success_total - sbase_reg;
        fdelta       = evt_reg.failure_total - fbase_reg;
        good_v       = good_reg;
        err_v        = err_reg;
        start_mode   = evt_reg.driver_start_ok ? M_INITIALIZING : M_ERROR;

        case (evt_reg.action)
            ACT_SERVICE:
            begin
                if (started_reg)
                begin
                    if (mode_reg == M_RESTART_WAIT || mode_reg == M_OFFLINE_WAIT)
                    begin
                        // Restart the driver once the wait has run out
                        wait_ms = (mode_reg == M_RESTART_WAIT) ? restart_delay_reg
                                                               : probe_period_reg;
                        if (elapsed(now_t, since_reg, wait_ms))
                        begin
                            bump     = 1'b1;
                            do_start = 1'b1;
                            drv      = 1'b1;
                        end
                    end
                    else if (mode_reg != M_BUS_WAIT && mode_reg != M_ERROR)
                    begin
                        if (evt_reg.bus_needs_recovery || evt_reg.bus_abort_error)
                        begin
                            // Raise a bus recovery request
                            pending_next = 1'b1;
                            reason_next  = REASON_BUS;
                            mode_next    = M_BUS_WAIT;
                            since_next   = now_t;
                        end
                        else
                        begin
                            // Count new good or failed samples
                            sbase_next = evt_reg.success_total;
                            fbase_next = evt_reg.failure_total;
                            if (sdelta != '0)
                            begin
                                err_v  = '0;
                                good_v = sat_add8(good_reg, sdelta);
                            end
                            else if (fdelta != '0)
                            begin
                                good_v = '0;
                                err_v  = sat_add8(err_reg, fdelta);
                            end

                            if (mode_reg == M_INITIALIZING)
                            begin
                                if (evt_reg.driver_condition == COND_ERROR)
                                begin
                                    mode_next  = M_OFFLINE_WAIT;
                                    since_next = now_t;
                                end
                                else if (evt_reg.driver_condition == COND_READY)
                                begin
                                    good_v     = '0;
                                    mode_next  = M_CONFIRMING;
                                    since_next = now_t;
                                end
                            end
                            else
                            begin
                                if (mode_reg == M_CONFIRMING && good_v >= confirm_good_reg)
                                begin
                                    mode_next  = M_ACTIVE;
                                    since_next = now_t;
                                end
                                if (err_v >= read_err_lim_reg)
                                begin
                                    reason_next = REASON_ERRORS;
                                    good_v      = '0;
                                    err_v       = '0;
                                    mode_next   = M_RESTART_WAIT;
                                    since_next  = now_t;
                                end
                                else
                                begin
                                    // Stale check against sample or mode start time
                                    fresh_t = evt_reg.sample_present ?
                                              time_t'(evt_reg.sample_time_ms) : since_next;
                                    if (!evt_reg.transfer_busy &&
                                        elapsed(now_t, fresh_t, stale_restart_reg))
                                    begin
                                        reason_next = REASON_STALE;
                                        good_v      = '0;
                                        err_v       = '0;
                                        mode_next   = M_RESTART_WAIT;
                                        since_next  = now_t;
                                    end
                                end
                            end
                            good_next = good_v;
                            err_next  = err_v;
                        end
                    end
                end
            end
            ACT_REPORT:
            begin
                if (started_reg && mode_reg != M_ERROR)
                begin
                    pending_next = 1'b0;
                    reason_next  = REASON_BUS;
                    if (evt_reg.recovery_ok)
                    begin
                        bump     = 1'b1;
                        do_start = 1'b1;
                        drv      = 1'b1;
                    end
                    else if (mode_reg != M_OFFLINE_WAIT)
                    begin
                        mode_next  = M_OFFLINE_WAIT;
                        since_next = now_t;
                    end
                end
            end
            ACT_TAKE:
            begin
                taken        = pending_reg;
                pending_next = 1'b0;
            end
            ACT_START:
            begin
                // Clear everything, then start if the configuration is sane
                mode_next    = M_NOT_STARTED;
                since_next   = '0;
                sbase_next   = '0;
                fbase_next   = '0;
                good_next    = '0;
                err_next     = '0;
                restart_next = '0;
                reason_next  = REASON_NONE;
                pending_next = 1'b0;
                started_next = 1'b0;
                if (cfg_bad)
                begin
                    mode_next = M_ERROR;
                end
                else
                begin
                    started_next = 1'b1;
                    do_start     = 1'b1;
                    drv          = 1'b1;
                end
            end
            default:
            begin
                taken = 1'b0;
            end
        endcase

        // Count a restart, holding at the maximum
        if (bump && restart_reg != '1)
            restart_next = restart_reg + 32'd1;

        // Driver start: take new bases, clear the run counters and the pending request, enter the start mode
        if (do_start)
        begin
            sbase_next   = evt_reg.success_total;
            fbase_next   = evt_reg.failure_total;
            good_next    = '0;
            err_next     = '0;
            pending_next = 1'b0;
            if (mode_next != start_mode)
            begin
                mode_next  = start_mode;
                since_next = now_t;
            end
        end

        res_next.mode             = mode_code(mode_next);
        res_next.online           = (mode_next == M_ACTIVE);
        res_next.started          = started_next;
        res_next.recovery_pending = pending_next;
        res_next.request_taken    = taken;
        res_next.restart_reason   = reason_next;
        res_next.restart_total    = restart_next;
        res_next.good_run         = good_next;
        res_next.error_run        = err_next;
        res_next.driver_restart   = drv;
    end

    // Hold configuration; ignore indexes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_delay_reg <= 32'd100;
            probe_period_reg  <= 32'd1000;
            stale_restart_reg <= 32'd2000;
            driver_stale_reg  <= 32'd500;
            read_err_lim_reg  <= 8'd3;
            confirm_good_reg  <= 8'd5;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RESTART_DELAY: restart_delay_reg <= cfg_data;
                CFG_PROBE_PERIOD:  probe_period_reg  <= cfg_data;
                CFG_STALE_RESTART: stale_restart_reg <= cfg_data;
                CFG_DRIVER_STALE:  driver_stale_reg  <= cfg_data;
                CFG_READ_ERR_LIM:  read_err_lim_reg  <= cfg_data[7:0];
                CFG_CONFIRM_GOOD:  confirm_good_reg  <= cfg_data[7:0];
                default:           restart_delay_reg <= restart_delay_reg;
            endcase
        end
    end

    // Advance the event register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            evt_valid_reg <= 1'b0;
        else if (evt_ready)
            evt_valid_reg <= evt_valid;
    end

    always_ff @(posedge clk)
    begin
        if (evt_ready && evt_valid)
            evt_reg <= evt;
    end

    // Commit state and result when the event fires
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_NOT_STARTED;
            since_reg     <= '0;
            sbase_reg     <= '0;
            fbase_reg     <= '0;
            good_reg      <= '0;
            err_reg       <= '0;
            restart_reg   <= '0;
            reason_reg    <= REASON_NONE;
            pending_reg   <= 1'b0;
            started_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg      <= mode_next;
            since_reg     <= since_next;
            sbase_reg     <= sbase_next;
            fbase_reg     <= fbase_next;
            good_reg      <= good_next;
            err_reg       <= err_next;
            restart_reg   <= restart_next;
            reason_reg    <= reason_next;
            pending_reg   <= pending_next;
            started_reg   <= started_next;
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res_next;
    end

endmodule

/* rtl/srs_checker.sv */
// Port-level checks of the sensor recovery supervisor, bound to its top level.
// Depends on srs_pkg and the assertion macro header.
`include "sensor_recovery_supervisor_top_assert.svh"

module srs_checker
    import srs_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      res_valid,
    input logic                      res_ready,
    input res_t                      res
);

    // A stalled result holds
    `SRS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result dropped or changed while stalled")

    // Online flag follows the active mode
    `SRS_ASSERT_IMPL(a_online_mode, res_valid, res.online == (res.mode == CODE_ACTIVE), "online disagrees with mode")

    // Taking a request leaves none pending
    `SRS_ASSERT_IMPL(a_take_clears, res_valid && res.request_taken, !res.recovery_pending, "request taken but still pending")

    // A driver start leaves the supervisor started in initializing or error
    `SRS_ASSERT_IMPL(a_drv_start, res_valid && res.driver_restart, res.started && !res.recovery_pending && (res.mode == CODE_INITIALIZING || res.mode == CODE_ERROR), "driver start left bad state")

    // No restarts are counted before a valid start
    `SRS_ASSERT_IMPL(a_unstarted, res_valid && !res.started, res.restart_total == 32'd0 && !res.online, "restart counted while not started")

endmodule

bind sensor_recovery_supervisor_top srs_checker u_srs_checker (.*);
